// ===== sv/sapq_pkg.sv =====
// Shared types and constants of the sorted-array priority queue.
// No dependencies; used by every module of the block and by its checker.
package sapq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int TAG_WIDTH_DEF = 32;
	localparam int CAP_W         = 7;
	localparam int PRIO_W        = 16;
	localparam int PORT_TAG_W    = 32;
	localparam int OCC_W         = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic                     req_type;
		logic signed [PRIO_W-1:0] priority_req;
		logic [PORT_TAG_W-1:0]    tag;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [PRIO_W-1:0] out_priority;
		logic [PORT_TAG_W-1:0]    out_tag;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic                     insert;
		logic                     pop;
		logic signed [PRIO_W-1:0] prio;
	} cell_ctl_t;

endpackage

// ===== sv/sorted_array_priority_queue.sv =====
// A result is registered on the clock edge that accepts its request.
// Throughput: one request per cycle while results are taken; a held result
// stalls requests. Every cell of the row updates in the same cycle.
// Reset: entry count cleared, capacity set to 64; cell contents are not cleared.
// Depends on sapq_pkg and sapq_cell.
module sorted_array_priority_queue #(
	parameter int DEPTH     = sapq_pkg::DEPTH_DEF,
	parameter int TAG_WIDTH = sapq_pkg::TAG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sapq_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sapq_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sapq_pkg::CAP_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LW    = (CNT_W > sapq_pkg::CAP_W) ? CNT_W : sapq_pkg::CAP_W;

	logic [CNT_W-1:0]           count_q, count_d;
	logic [sapq_pkg::CAP_W-1:0] cap_q;
	sapq_pkg::rsp_t             rsp_q, rsp_d;
	logic                       rsp_valid_q;

	logic [LW-1:0] cap_w, lim_w, cnt_w, cnt_next_w;
	logic          accept, full, empty, do_ins, do_pop;
	logic [63:0]   tag_in_w, tag_out_w;

	sapq_pkg::cell_ctl_t        ctl;
	logic [TAG_WIDTH-1:0]       new_tag;

	logic                               ge_c   [DEPTH];
	logic signed [sapq_pkg::PRIO_W-1:0] prio_c [DEPTH];
	logic [TAG_WIDTH-1:0]               tag_c  [DEPTH];

	assign cfg_ready = 1'b1;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign cap_w = LW'(cap_q);
	assign lim_w = (cap_w < LW'(DEPTH)) ? cap_w : LW'(DEPTH);
	assign cnt_w = LW'(count_q);
	assign full  = cnt_w >= lim_w;
	assign empty = count_q == '0;

	assign do_ins = accept && (req.req_type == sapq_pkg::REQ_INSERT) && !full;
	assign do_pop = accept && (req.req_type == sapq_pkg::REQ_POP) && !empty;

	assign tag_in_w  = 64'(req.tag);
	assign new_tag   = tag_in_w[TAG_WIDTH-1:0];
	assign tag_out_w = 64'(tag_c[0]);

	assign ctl.insert = do_ins;
	assign ctl.pop    = do_pop;
	assign ctl.prio   = req.priority_req;

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_d = count_q - CNT_W'(1);
		end
		cnt_next_w = LW'(count_d);
		rsp_d.out_priority = '0;
		rsp_d.out_tag      = '0;
		rsp_d.occupancy    = cnt_next_w[sapq_pkg::OCC_W-1:0];
		if (req.req_type == sapq_pkg::REQ_INSERT) begin
			rsp_d.status = full ? sapq_pkg::ST_FULL : sapq_pkg::ST_INSERTED;
		end else if (empty) begin
			rsp_d.status = sapq_pkg::ST_EMPTY;
		end else begin
			rsp_d.status       = sapq_pkg::ST_POPPED;
			rsp_d.out_priority = prio_c[0];
			rsp_d.out_tag      = tag_out_w[sapq_pkg::PORT_TAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= sapq_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                               l_ge;
		logic signed [sapq_pkg::PRIO_W-1:0] l_prio, r_prio;
		logic [TAG_WIDTH-1:0]               l_tag, r_tag;

		if (i == 0) begin : g_first
			assign l_ge   = 1'b0;
			assign l_prio = '0;
			assign l_tag  = '0;
		end else begin : g_mid_l
			assign l_ge   = ge_c[i-1];
			assign l_prio = prio_c[i-1];
			assign l_tag  = tag_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_prio = '0;
			assign r_tag  = '0;
		end else begin : g_mid_r
			assign r_prio = prio_c[i+1];
			assign r_tag  = tag_c[i+1];
		end

		sapq_cell #(
			.IDX       (i),
			.CNT_W     (CNT_W),
			.TAG_WIDTH (TAG_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_tag    (new_tag),
			.count      (count_q),
			.left_ge    (l_ge),
			.left_prio  (l_prio),
			.left_tag   (l_tag),
			.right_prio (r_prio),
			.right_tag  (r_tag),
			.ge         (ge_c[i]),
			.prio       (prio_c[i]),
			.tag        (tag_c[i])
		);
	end

endmodule

// ===== sv/sapq_cell.sv =====
// One slot of the queue chain: holds an entry and shifts with its neighbours.
// Depends on sapq_pkg for the cell control struct.
module sapq_cell #(
	parameter int IDX       = 0,
	parameter int CNT_W     = 7,
	parameter int TAG_WIDTH = sapq_pkg::TAG_WIDTH_DEF
) (
	input  logic                             clk,
	input  sapq_pkg::cell_ctl_t              ctl,
	input  logic [TAG_WIDTH-1:0]             new_tag,
	input  logic [CNT_W-1:0]                 count,
	input  logic                             left_ge,
	input  logic signed [sapq_pkg::PRIO_W-1:0] left_prio,
	input  logic [TAG_WIDTH-1:0]             left_tag,
	input  logic signed [sapq_pkg::PRIO_W-1:0] right_prio,
	input  logic [TAG_WIDTH-1:0]             right_tag,
	output logic                             ge,
	output logic signed [sapq_pkg::PRIO_W-1:0] prio,
	output logic [TAG_WIDTH-1:0]             tag
);

	localparam int IW = (CNT_W > 32) ? CNT_W : 32;

	logic signed [sapq_pkg::PRIO_W-1:0] prio_q;
	logic [TAG_WIDTH-1:0]               tag_q;
	logic                               occupied;
	logic [IW-1:0]                      count_w;

	assign count_w  = IW'(count);
	assign occupied = count_w > IW'(IDX);
	// entry moves down (or is free) when the new priority is at least its own
	assign ge       = !occupied || (prio_q <= ctl.prio);
	assign prio     = prio_q;
	assign tag      = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end else if (ctl.insert && ge) begin
			if (!left_ge) begin
				prio_q <= ctl.prio;
				tag_q  <= new_tag;
			end else begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end
		end
	end

endmodule

// ===== sv/sapq_checker.sv =====
// Port-level checks of the sorted-array priority queue, bound to its top level.
// Depends on sapq_pkg and sorted_array_priority_queue.
module sapq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input sapq_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_insert_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sapq_pkg::ST_INSERTED |-> rsp.occupancy != '0)
		else $error("insert left queue empty");

	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != sapq_pkg::ST_POPPED
		|-> rsp.out_priority == '0 && rsp.out_tag == '0)
		else $error("entry data on a non-pop result");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sapq_pkg::ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty result with entries held");

	a_accept_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request gave no result");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== test/sapq_order_checker.sv =====
// Checker for the sorted-array priority queue: watches the request, response and
// capacity channels, keeps a shadow copy of the queue and compares every response.
// Depends on sapq_pkg.
module sapq_order_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  sapq_pkg::req_t             req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  sapq_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [sapq_pkg::CAP_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         owed,
	output int                         n_inserted,
	output int                         n_full,
	output int                         n_popped,
	output int                         n_empty
);
	timeunit 1ns;
	timeprecision 1ps;

	import sapq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
	logic [PORT_TAG_W-1:0]    shadow_tag [DEPTH];
	int                       shadow_count;
	logic [CAP_W-1:0]         shadow_cap;
	rsp_t                     answers_due [$];

	function automatic rsp_t serve_request(req_t r);
		rsp_t a;
		int   lim;
		int   pos;
		int   i;
		a = '0;
		lim = (int'(shadow_cap) < DEPTH) ? int'(shadow_cap) : DEPTH;
		if (r.req_type == REQ_INSERT) begin
			if (shadow_count >= lim) begin
				a.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= r.priority_req)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_tag[i]  = shadow_tag[i-1];
				end
				shadow_prio[pos] = r.priority_req;
				shadow_tag[pos]  = r.tag;
				shadow_count++;
				a.status = ST_INSERTED;
			end
		end else if (shadow_count == 0) begin
			a.status = ST_EMPTY;
		end else begin
			shadow_count--;
			a.status       = ST_POPPED;
			a.out_priority = shadow_prio[shadow_count];
			a.out_tag      = shadow_tag[shadow_count];
		end
		a.occupancy = OCC_W'(shadow_count);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_cap   = CAP_RESET;
			answers_due.delete();
			fail_count   = 0;
			n_inserted   = 0;
			n_full       = 0;
			n_popped     = 0;
			n_empty      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				shadow_cap = cfg_data;
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					fail_count++;
					$error("response with no request outstanding");
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status) begin
						fail_count++;
						$error("status: expected %0d, got %0d", want.status, rsp.status);
					end
					if (rsp.out_priority !== want.out_priority) begin
						fail_count++;
						$error("out_priority: expected %0d, got %0d",
							want.out_priority, rsp.out_priority);
					end
					if (rsp.out_tag !== want.out_tag) begin
						fail_count++;
						$error("out_tag: expected %h, got %h", want.out_tag, rsp.out_tag);
					end
					if (rsp.occupancy !== want.occupancy) begin
						fail_count++;
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, rsp.occupancy);
					end
				end
			end
			if (req_valid && req_ready) begin
				want = serve_request(req);
				answers_due.push_back(want);
				case (want.status)
					ST_INSERTED: n_inserted++;
					ST_FULL:     n_full++;
					ST_POPPED:   n_popped++;
					default:     n_empty++;
				endcase
			end
		end
		owed = answers_due.size();
	end

endmodule

// ===== test/tb.sv =====
// Top of the priority queue testbench: clock, reset, request and capacity stimulus,
// response back-pressure and the final verdict.
// Depends on sapq_pkg, sorted_array_priority_queue and sapq_order_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sapq_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int PHASE_ITEMS     = 50;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY3} rx_pattern_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	int   fail_count;
	int   owed;
	int   n_inserted;
	int   n_full;
	int   n_popped;
	int   n_empty;
	int   n_settings;
	int   burst_left;
	logic hold_off_go;

	sorted_array_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sapq_order_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.owed       (owed),
		.n_inserted (n_inserted),
		.n_full     (n_full),
		.n_popped   (n_popped),
		.n_empty    (n_empty)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic req_t make_req(logic kind, logic [PRIO_W-1:0] p,
			logic [PORT_TAG_W-1:0] t);
		req_t r;
		r.req_type     = kind;
		r.priority_req = p;
		r.tag          = t;
		return r;
	endfunction

	function automatic req_t random_req(int insert_pct);
		logic [PRIO_W-1:0] p;
		int                style;
		style = $urandom_range(0, 9);
		if (style < 5)
			p = PRIO_W'($urandom);
		else if (style < 8)
			p = PRIO_W'($urandom_range(0, 4) - 2);
		else
			case ($urandom_range(0, 3))
				0: p = 16'h8000;
				1: p = 16'h7FFF;
				2: p = 16'hFFFF;
				default: p = 16'h0000;
			endcase
		return make_req(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP,
			p, $urandom);
	endfunction

	task automatic push_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		rx_pattern_t pattern;
		int          left;
		int          tick;
		int          hold_left;
		rsp_ready = 1'b0;
		pattern   = RX_OPEN;
		left      = 0;
		tick      = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				if (left == 0) begin
					pattern = rx_pattern_t'($urandom_range(0, 3));
					left    = $urandom_range(1, 64);
				end
				left--;
				tick++;
				case (pattern)
					RX_OPEN:   rsp_ready <= 1'b1;
					RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
					default:   rsp_ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int caps [10];
		int n;
		int k;
		int pct;
		caps = '{64, 1, 127, 3, 17, 64, 100, 2, 40, 64};
		req_valid   = 1'b0;
		req         = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		burst_left  = 0;
		n_settings  = 0;
		hold_off_go = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pop, extremes, ties served newest first
		push_request(make_req(REQ_POP, 16'h7FFF, 32'hFFFF_FFFF));
		push_request(make_req(REQ_INSERT, 16'h8000, 32'h0000_0000));
		push_request(make_req(REQ_INSERT, 16'h7FFF, 32'hFFFF_FFFF));
		push_request(make_req(REQ_INSERT, 16'h0000, 32'hA5A5_0001));
		push_request(make_req(REQ_INSERT, 16'h0000, 32'h5A5A_0002));
		push_request(make_req(REQ_INSERT, 16'hFFFF, 32'h0000_0003));
		for (k = 0; k < 6; k++)
			push_request(make_req(REQ_POP, 16'h0000, 32'h0000_0000));

		// capacity of one
		settle();
		write_capacity(7'd1);
		push_request(make_req(REQ_INSERT, 16'h0005, 32'h1111_1111));
		push_request(make_req(REQ_INSERT, 16'h0006, 32'h2222_2222));
		push_request(make_req(REQ_POP, 16'h0000, 32'h0000_0000));
		push_request(make_req(REQ_POP, 16'h0000, 32'h0000_0000));

		// capacity of zero rejects inserts; the pop finds the queue empty
		settle();
		write_capacity(7'd0);
		push_request(make_req(REQ_INSERT, 16'h0001, 32'h3333_3333));
		push_request(make_req(REQ_POP, 16'h0000, 32'h0000_0000));

		// count left above a lowered capacity
		settle();
		write_capacity(7'd64);
		for (k = 0; k < 3; k++)
			push_request(make_req(REQ_INSERT, PRIO_W'(k), 32'h4444_0000 + k));
		settle();
		write_capacity(7'd2);
		push_request(make_req(REQ_INSERT, 16'h0010, 32'h5555_5555));
		push_request(make_req(REQ_POP, 16'h0000, 32'h0000_0000));

		for (n = 0; n < 10; n++) begin
			settle();
			write_capacity((n == 9) ? CAP_W'($urandom_range(1, 64)) : CAP_W'(caps[n]));
			pct = $urandom_range(35, 80);
			if (n == 5) begin
				hold_off_go = 1'b1;
				for (k = 0; k < PHASE_ITEMS + 10; k++)
					push_request(random_req(60));
			end else begin
				for (k = 0; k < PHASE_ITEMS; k++)
					push_request(random_req(pct));
			end
		end

		// fill past the array size with an oversized capacity, then drain past empty
		settle();
		write_capacity(7'd127);
		for (k = 0; k < DEPTH_DEF + 2; k++)
			push_request(random_req(100));
		for (k = 0; k < DEPTH_DEF + 2; k++)
			push_request(random_req(0));
		settle();

		$display("Covered %0d inserts, %0d full rejections, %0d pops and %0d empty pops",
			n_inserted, n_full, n_popped, n_empty);
		$display("over %0d capacity writes spanning 0 to 127, with long response stalls.",
			n_settings);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sapq_pkg.sv
sv/sapq_cell.sv
sv/sorted_array_priority_queue.sv
sv/sapq_checker.sv
test/sapq_order_checker.sv
test/tb.sv
